### rtl/core/psfp_pkg.sv
// Package: shared constants and types of the particle sensor frame parser.
`timescale 1ns / 1ps

package psfp_pkg;

  // Field widths of the byte and result words
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned POS_W   = 5;

  // Frame layout constants
  localparam logic [BYTE_W-1:0] START_BYTE      = 8'h42;
  localparam int unsigned       WORD_FIRST_BYTE = 4;
  localparam int unsigned       MAX_WORDS       = 12;

  // Result status codes
  localparam logic STATUS_GOOD     = 1'b0;
  localparam logic STATUS_MISMATCH = 1'b1;

  // Parser sequencer states
  typedef enum logic [1:0] {
    ST_HUNT,
    ST_FRAME,
    ST_DRAIN
  } psfp_state_e;

  // Write request into the measurement store
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [VALUE_W-1:0] data;
  } psfp_wr_req_t;

  // Read request into the measurement store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } psfp_rd_req_t;

endpackage

### rtl/core/psfp_if.sv
// Interfaces: received byte channel and measurement result channel.
`timescale 1ns / 1ps

interface psfp_byte_if;
  import psfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface psfp_result_if;
  import psfp_pkg::*;

  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   word_index;
  logic [VALUE_W-1:0] word_value;
  logic               frame_status;
  logic               last_of_frame;

  modport source (output valid, output word_index, output word_value,
                  output frame_status, output last_of_frame, input ready);
  modport sink   (input valid, input word_index, input word_value,
                  input frame_status, input last_of_frame, output ready);
endinterface

### rtl/core/psfp_word_store.sv
// Measurement word store: one write port, one registered read port.
`timescale 1ns / 1ps

module psfp_word_store (
  input  logic                           clk_i,
  input  psfp_pkg::psfp_wr_req_t         wr_i,
  input  psfp_pkg::psfp_rd_req_t         rd_i,
  output logic [psfp_pkg::VALUE_W-1:0]   rdata_o
);
  import psfp_pkg::*;

  logic [VALUE_W-1:0] mem_q [MAX_WORDS];
  logic [VALUE_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Read port, registered; data holds between reads
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/particle_sensor_frame_parser_unit.sv
// Top level: particle sensor frame parser with checksum check and word drain.
`timescale 1ns / 1ps

// Takes one received byte per handshake. Bytes are dropped until a 0x42 start
// byte, then a frame of FRAME_BYTES bytes is collected byte by byte; the
// measurement words go into a small synchronous store as they complete.
// On the final byte a checksum mismatch gives a single error word at once; a
// match starts a drain that reads the store one word per cycle, pausing while
// the output is stalled, and sends the words in order, the last flagged. No
// byte is taken during the drain, and the final byte of a frame waits while the
// previous result word is still unaccepted.
module particle_sensor_frame_parser_unit #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  psfp_byte_if.sink     rx_i,
  psfp_result_if.source res_o
);
  import psfp_pkg::*;

  // Number of words carried in a frame of this length
  localparam int unsigned NW_RAW = (FRAME_BYTES < 8) ? 1 : (FRAME_BYTES - 6) / 2;
  localparam int unsigned NW     = (NW_RAW > MAX_WORDS) ? MAX_WORDS : NW_RAW;
  localparam logic [POS_W-1:0] POS_CHK_HI = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_WORD0  = POS_W'(WORD_FIRST_BYTE);
  localparam logic [POS_W-1:0] POS_WEND   = POS_W'(WORD_FIRST_BYTE + 2 * NW);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(NW - 1);

  psfp_state_e state_q, state_d;

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [VALUE_W-1:0] sum_q, sum_d;
  logic [BYTE_W-1:0]  high_q, high_d;
  logic [BYTE_W-1:0]  chk_hi_q, chk_hi_d;

  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic               rd_done_q, rd_done_d;
  logic               rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0]   pend_idx_q, pend_idx_d;

  logic               out_valid_q, out_valid_d;
  logic [IDX_W-1:0]   out_idx_q, out_idx_d;
  logic [VALUE_W-1:0] out_val_q, out_val_d;
  logic               out_status_q, out_status_d;
  logic               out_last_q, out_last_d;

  psfp_wr_req_t       wr_req;
  psfp_rd_req_t       rd_req;
  logic [VALUE_W-1:0] rdata;

  logic               accept;
  logic               at_last;
  logic               chk_match;
  logic               out_free;
  logic               pend_take;
  logic               issue;
  logic [POS_W-1:0]   word_off;

  // Handshake and frame position decode
  assign at_last   = (pos_q == POS_LAST);
  assign accept    = rx_i.valid && rx_i.ready;
  assign chk_match = ({chk_hi_q, rx_i.rx_byte} == sum_q);
  assign out_free  = !out_valid_q || res_o.ready;
  assign pend_take = rd_pend_q && out_free;
  assign issue     = (state_q == ST_DRAIN) && !rd_done_q && (!rd_pend_q || pend_take);
  assign word_off  = pos_q - POS_WORD0;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_HUNT: begin
        if (accept && rx_i.rx_byte == START_BYTE) begin
          state_d = ST_FRAME;
        end
      end
      ST_FRAME: begin
        if (accept && at_last) begin
          state_d = chk_match ? ST_DRAIN : ST_HUNT;
        end
      end
      ST_DRAIN: begin
        if (pend_take && pend_idx_q == IDX_LAST) begin
          state_d = ST_HUNT;
        end
      end
      default: state_d = ST_HUNT;
    endcase
  end

  // Ready: hold off during the drain, and hold the final byte while a word waits
  always_comb begin
    unique case (state_q)
      ST_HUNT:  rx_i.ready = 1'b1;
      ST_FRAME: rx_i.ready = !(at_last && out_valid_q);
      ST_DRAIN: rx_i.ready = 1'b0;
      default:  rx_i.ready = 1'b0;
    endcase
  end

  // Frame collection: position, running sum, word assembly, checksum
  always_comb begin
    pos_d       = pos_q;
    sum_d       = sum_q;
    high_d      = high_q;
    chk_hi_d    = chk_hi_q;
    wr_req.en   = 1'b0;
    wr_req.addr = word_off[IDX_W:1];
    wr_req.data = {high_q, rx_i.rx_byte};
    if (accept) begin
      if (state_q == ST_HUNT) begin
        if (rx_i.rx_byte == START_BYTE) begin
          pos_d = POS_W'(1);
          sum_d = VALUE_W'(START_BYTE);
        end
      end else if (pos_q < POS_CHK_HI) begin
        sum_d = sum_q + VALUE_W'(rx_i.rx_byte);
        pos_d = pos_q + POS_W'(1);
        if (pos_q >= POS_WORD0 && pos_q < POS_WEND) begin
          if (!word_off[0]) begin
            high_d = rx_i.rx_byte;
          end else begin
            wr_req.en = 1'b1;
          end
        end
      end else if (pos_q == POS_CHK_HI) begin
        chk_hi_d = rx_i.rx_byte;
        pos_d    = pos_q + POS_W'(1);
      end else begin
        pos_d = '0;
      end
    end
  end

  // Drain sequencing: store reads and the pending read word
  always_comb begin
    rd_idx_d    = rd_idx_q;
    rd_done_d   = rd_done_q;
    rd_pend_d   = rd_pend_q;
    pend_idx_d  = pend_idx_q;
    rd_req.en   = issue;
    rd_req.addr = rd_idx_q;
    if (state_q == ST_FRAME && accept && at_last) begin
      rd_idx_d  = '0;
      rd_done_d = 1'b0;
    end
    if (pend_take) begin
      rd_pend_d = 1'b0;
    end
    if (issue) begin
      rd_pend_d  = 1'b1;
      pend_idx_d = rd_idx_q;
      rd_idx_d   = rd_idx_q + IDX_W'(1);
      rd_done_d  = (rd_idx_q == IDX_LAST);
    end
  end

  // Output word register
  always_comb begin
    out_valid_d  = out_valid_q && !res_o.ready;
    out_idx_d    = out_idx_q;
    out_val_d    = out_val_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    if (state_q == ST_FRAME && accept && at_last && !chk_match) begin
      out_valid_d  = 1'b1;
      out_idx_d    = '0;
      out_val_d    = '0;
      out_status_d = STATUS_MISMATCH;
      out_last_d   = 1'b1;
    end else if (pend_take) begin
      out_valid_d  = 1'b1;
      out_idx_d    = pend_idx_q;
      out_val_d    = rdata;
      out_status_d = STATUS_GOOD;
      out_last_d   = (pend_idx_q == IDX_LAST);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_HUNT;
      pos_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_done_q   <= 1'b1;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      rd_pend_q   <= rd_pend_d;
      rd_done_q   <= rd_done_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sum_q        <= sum_d;
    high_q       <= high_d;
    chk_hi_q     <= chk_hi_d;
    pend_idx_q   <= pend_idx_d;
    out_idx_q    <= out_idx_d;
    out_val_q    <= out_val_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  psfp_word_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr_req),
    .rd_i    (rd_req),
    .rdata_o (rdata)
  );

  assign res_o.valid         = out_valid_q;
  assign res_o.word_index    = out_idx_q;
  assign res_o.word_value    = out_val_q;
  assign res_o.frame_status  = out_status_q;
  assign res_o.last_of_frame = out_last_q;

  // A read word that cannot move on stays pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_pend_q && !out_free) |=> rd_pend_q)
    else $error("pending store word lost while output stalled");

  // An error word always closes its frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.frame_status) |-> res_o.last_of_frame)
    else $error("mismatch word not marked last");

  // Word indices stay within the frame's word count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.word_index <= IDX_LAST))
    else $error("word index beyond frame");

  // Leaving the drain only happens with the last word loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && state_d != ST_DRAIN) |=> (out_valid_q && out_last_q))
    else $error("drain ended without last word");

endmodule

### test/particle_sensor_frame_parser_unit_test.sv
// Testbench: frame parser checked word by word against a byte-level parser model.
`timescale 1ns / 1ps

module particle_sensor_frame_parser_unit_test;
  import psfp_pkg::*;

  // Frame layout as built by the default parameter of the block
  localparam int FRAME_LEN  = 32;
  localparam int WORD_COUNT = ((FRAME_LEN - 6) / 2 > MAX_WORDS) ? MAX_WORDS
                                                                : (FRAME_LEN - 6) / 2;
  localparam int CALM_TAIL  = 60;
  localparam int DRAIN_WAIT = 60;

  // One measurement word as seen on the result channel
  typedef struct {
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] value;
    logic               status;
    logic               last;
  } meas_word_t;

  logic clk_i;
  logic rst_ni;

  psfp_byte_if   byte_bus ();
  psfp_result_if word_bus ();

  particle_sensor_frame_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (byte_bus),
    .res_o  (word_bus)
  );

  // Bytes still to send and words still to arrive
  logic [BYTE_W-1:0] pending_bytes[$];
  meas_word_t        expected_words[$];

  int total_bytes;
  int bytes_taken;
  int words_seen;
  int mismatches;
  int good_frames;
  int bad_frames;
  int send_gap;
  int stall_left;
  bit calm;

  // Parser model state
  logic [POS_W-1:0]   mdl_pos;
  logic               mdl_in_frame;
  logic [VALUE_W-1:0] mdl_sum;
  logic [BYTE_W-1:0]  mdl_high;
  logic [VALUE_W-1:0] mdl_checksum;
  logic [VALUE_W-1:0] mdl_store[MAX_WORDS];

  assign calm = (bytes_taken + CALM_TAIL >= total_bytes);

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Advance the parser model by one accepted byte, queueing any words it frees
  task automatic parse_byte(input logic [BYTE_W-1:0] b);
    int p;
    int off;
    meas_word_t w;
    p = mdl_pos;
    if (!mdl_in_frame) begin
      if (b == START_BYTE) begin
        mdl_in_frame = 1'b1;
        mdl_sum      = VALUE_W'(START_BYTE);
        mdl_pos      = POS_W'(1);
      end
    end else if (p + 2 < FRAME_LEN) begin
      mdl_sum = mdl_sum + VALUE_W'(b);
      if (p >= WORD_FIRST_BYTE && p < WORD_FIRST_BYTE + 2 * WORD_COUNT) begin
        off = p - WORD_FIRST_BYTE;
        if (off % 2 == 0) mdl_high = b;
        else mdl_store[off / 2] = {mdl_high, b};
      end
      mdl_pos = POS_W'(p + 1);
    end else if (p + 2 == FRAME_LEN) begin
      mdl_checksum = {b, 8'h00};
      mdl_pos      = POS_W'(p + 1);
    end else begin
      // final byte: checksum decides between the word list and one error word
      mdl_checksum = {mdl_checksum[15:8], b};
      mdl_in_frame = 1'b0;
      mdl_pos      = '0;
      if (mdl_checksum != mdl_sum) begin
        w.idx    = '0;
        w.value  = '0;
        w.status = STATUS_MISMATCH;
        w.last   = 1'b1;
        expected_words.push_back(w);
        bad_frames++;
      end else begin
        for (int k = 0; k < WORD_COUNT; k++) begin
          w.idx    = IDX_W'(k);
          w.value  = mdl_store[k];
          w.status = STATUS_GOOD;
          w.last   = (k == WORD_COUNT - 1);
          expected_words.push_back(w);
        end
        good_frames++;
      end
    end
  endtask

  // Random byte leaning towards the extremes and the start code
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return START_BYTE;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Queue one whole frame; style 0 random, 1 extreme words, 2 all ones
  task automatic add_frame(input int style, input bit corrupt);
    logic [BYTE_W-1:0]  body[FRAME_LEN];
    logic [VALUE_W-1:0] sum;
    int                 w;
    body[0] = START_BYTE;
    for (int i = 1; i < FRAME_LEN - 2; i++) begin
      case (style)
        1: begin
          w = (i - WORD_FIRST_BYTE) / 2;
          if (i < WORD_FIRST_BYTE) body[i] = BYTE_W'(i);
          else case (w % 3)
            0: body[i] = 8'h00;
            1: body[i] = 8'hFF;
            default: body[i] = (i % 2 == 0) ? START_BYTE : 8'h81;
          endcase
        end
        2: body[i] = 8'hFF;
        default: body[i] = pick_byte();
      endcase
    end
    sum = '0;
    for (int i = 0; i < FRAME_LEN - 2; i++) sum = sum + VALUE_W'(body[i]);
    if (corrupt) sum = sum ^ (VALUE_W'(1) << $urandom_range(0, VALUE_W - 1));
    body[FRAME_LEN - 2] = sum[15:8];
    body[FRAME_LEN - 1] = sum[7:0];
    for (int i = 0; i < FRAME_LEN; i++) pending_bytes.push_back(body[i]);
  endtask

  // Queue bytes the parser should drop while hunting
  task automatic add_noise(input int count);
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < count; i++) begin
      do b = BYTE_W'($urandom_range(0, 255)); while (b == START_BYTE);
      pending_bytes.push_back(b);
    end
  endtask

  // Byte driver: holds each byte until taken, with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      byte_bus.valid   <= 1'b0;
      byte_bus.rx_byte <= '0;
    end else begin
      if (byte_bus.valid && byte_bus.ready) begin
        parse_byte(byte_bus.rx_byte);
        void'(pending_bytes.pop_front());
        bytes_taken++;
      end
      if (!byte_bus.valid || byte_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          byte_bus.valid <= 1'b0;
        end else if (pending_bytes.size() == 0) begin
          byte_bus.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 14) - 1;
          byte_bus.valid <= 1'b0;
        end else begin
          byte_bus.valid   <= 1'b1;
          byte_bus.rx_byte <= pending_bytes[0];
        end
      end
    end
  end

  // Word monitor: random back-pressure, each taken word checked in order
  always @(posedge clk_i) begin
    meas_word_t w;
    if (!rst_ni) begin
      word_bus.ready <= 1'b0;
    end else begin
      if (word_bus.valid && word_bus.ready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word idx=%0d value=%h status=%b last=%b", $realtime,
                     word_bus.word_index, word_bus.word_value, word_bus.frame_status,
                     word_bus.last_of_frame);
        end else begin
          w = expected_words.pop_front();
          if (word_bus.word_index !== w.idx || word_bus.word_value !== w.value ||
              word_bus.frame_status !== w.status || word_bus.last_of_frame !== w.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: word mismatch exp idx=%0d value=%h status=%b last=%b",
                       $realtime, w.idx, w.value, w.status, w.last);
              $display("%0t:   got idx=%0d value=%h status=%b last=%b", $realtime,
                       word_bus.word_index, word_bus.word_value, word_bus.frame_status,
                       word_bus.last_of_frame);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        word_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        word_bus.ready <= 1'b0;
      end else begin
        word_bus.ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int target;
    int pick;
    rst_ni           = 1'b0;
    byte_bus.valid   = 1'b0;
    byte_bus.rx_byte = '0;
    word_bus.ready   = 1'b0;
    bytes_taken = 0;
    words_seen  = 0;
    mismatches  = 0;
    good_frames = 0;
    bad_frames  = 0;
    send_gap    = 0;
    stall_left  = 0;
    mdl_pos      = '0;
    mdl_in_frame = 1'b0;
    mdl_sum      = '0;
    mdl_high     = '0;
    mdl_checksum = '0;
    foreach (mdl_store[i]) mdl_store[i] = '0;

    // directed: hunting noise, extreme words with start codes inside, bad sum
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h41);
    pending_bytes.push_back(8'h43);
    add_frame(1, 1'b0);
    add_frame(2, 1'b1);
    add_frame(2, 1'b0);

    // random: mostly well-formed frames, some bad sums, noise and cut frames
    target = pending_bytes.size() + 140;
    while (pending_bytes.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) add_frame(0, 1'b0);
      else if (pick < 85) add_frame(0, 1'b1);
      else if (pick < 95) add_noise($urandom_range(1, 5));
      else begin
        pending_bytes.push_back(START_BYTE);
        for (int i = $urandom_range(1, 20); i > 0; i--) pending_bytes.push_back(pick_byte());
      end
    end
    // flush any frame left open by a cut frame, then end on a clean one
    add_frame(0, 1'b0);
    add_frame(0, 1'b0);
    total_bytes = pending_bytes.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (bytes_taken < total_bytes || expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    mismatches += expected_words.size();

    $display("Sent %0d bytes: %0d frames with good checksum, %0d with bad checksum.",
             bytes_taken, good_frames, bad_frames);
    $display("Checked %0d result words, %0d mismatches.", words_seen, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
rtl/core/psfp_pkg.sv
rtl/core/psfp_if.sv
rtl/core/psfp_word_store.sv
rtl/core/particle_sensor_frame_parser_unit.sv
test/particle_sensor_frame_parser_unit_test.sv
